// File: rtl/core/clsr_pkg.sv
// types and constants shared by the combined lcg shuffle generator
`default_nettype none
package clsr_pkg;

  localparam logic [30:0] MOD1     = 31'd2147483563;
  localparam logic [30:0] MOD2     = 31'd2147483399;
  localparam logic [15:0] MUL1     = 16'd40014;
  localparam logic [15:0] MUL2     = 16'd40692;
  localparam logic [7:0]  FOLD1    = 8'd85;
  localparam logic [7:0]  FOLD2    = 8'd249;
  localparam logic [7:0]  FRAC_MUL = 8'd170;
  localparam logic [30:0] RAW_TOP  = 31'd2147483562;
  localparam logic [31:0] FRAC_CAP = 32'd4294966780;
  localparam logic [30:0] Y_INIT   = 31'd123456789;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_MUL,
    ST_RED
  } clsr_state_t;

  typedef struct packed {
    logic load_seed;
    logic mul;
    logic red_seed;
    logic red_next;
  } clsr_cmd_t;

  typedef struct packed {
    logic busy;
    logic cnt_zero;
  } clsr_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/clsr_ctrl.sv
// sequencer for seeding and deviate steps
`default_nettype none
module clsr_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_func,
  output logic                  in_ready,
  input  clsr_pkg::clsr_sts_t   sts,
  output clsr_pkg::clsr_cmd_t   cmd
);
  import clsr_pkg::*;

  clsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !sts.busy;
        if (in_valid && !sts.busy) begin
          if (in_func) begin
            cmd.load_seed = 1'b1;
            state_nxt     = ST_SEED_MUL;
          end else begin
            cmd.mul   = 1'b1;
            state_nxt = ST_RED;
          end
        end
      end
      ST_SEED_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        cmd.red_seed = 1'b1;
        state_nxt    = sts.cnt_zero ? ST_MUL : ST_SEED_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.red_next = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/clsr_dp.sv
// generators, shuffle table, slot select and output word register
`default_nettype none
module clsr_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [30:0]           in_seed_value,
  input  clsr_pkg::clsr_cmd_t   cmd,
  output clsr_pkg::clsr_sts_t   sts,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [30:0]           out_raw_value,
  output logic [31:0]           out_unit_fraction
);
  import clsr_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int CW       = $clog2(TABLE_DEPTH + 8);
  localparam int SLOT_DIV = 1 + int'(RAW_TOP) / TABLE_DEPTH;

  function automatic logic [30:0] mod_fold(input logic [46:0] p, input logic [30:0] m,
                                           input logic [7:0] fold);
    logic [23:0] hf;
    logic [31:0] s;
    hf = 24'(p[46:31]) * 24'(fold);
    s  = {1'b0, p[30:0]} + {8'b0, hf};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[30:0];
  endfunction

  function automatic logic [31:0] to_frac(input logic [30:0] v);
    logic [38:0] t;
    logic [14:0] qf;
    logic [31:0] r;
    logic [32:0] f;
    t  = 39'(v) * 39'(FRAC_MUL);
    qf = 15'(t[38:31]) * 15'(FOLD1);
    r  = {1'b0, t[30:0]} + {17'b0, qf};
    f  = {1'b0, v, 1'b0} + 33'(t[38:31]) + 33'(r >= {1'b0, MOD1});
    if (f > {1'b0, FRAC_CAP}) return FRAC_CAP;
    return f[31:0];
  endfunction

  logic [30:0]          x_r, x_nxt, y_r, y_nxt, last_r, last_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [46:0]          p1_r, p2_r;
  logic [AW-1:0]        slot_r, slot;
  logic [30:0]          tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  logic [30:0]          rd_r;
  logic                 rd_vld_r;
  logic                 res_pend_r, out_valid_r;
  logic [30:0]          out_raw_r;
  logic [31:0]          out_frac_r;
  logic [TABLE_DEPTH:0] ge;
  logic [TABLE_DEPTH-1:0] edge_hit;
  logic [30:0]          seed_eff, x_red, y_red, sel, last_new;
  logic [31:0]          diff;
  logic                 tbl_we, out_load;
  logic [AW-1:0]        tbl_wa;

  // slot = last / SLOT_DIV via constant thresholds
  assign ge[0]           = 1'b1;
  assign ge[TABLE_DEPTH] = 1'b0;
  for (genvar k = 1; k < TABLE_DEPTH; k++) begin : g_thr
    localparam logic [31:0] THR = 32'(k * SLOT_DIV);
    assign ge[k] = {1'b0, last_r} >= THR;
  end

  always_comb begin
    slot = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      edge_hit[k] = ge[k] & ~ge[k+1];
      if (edge_hit[k]) slot = slot | AW'(k);
    end
  end

  assign seed_eff = (in_seed_value == '0) ? 31'd1 : in_seed_value;
  assign x_red    = mod_fold(p1_r, MOD1, FOLD1);
  assign y_red    = mod_fold(p2_r, MOD2, FOLD2);
  assign sel      = rd_vld_r ? rd_r : '0;

  always_comb begin
    if ({1'b0, sel} > {1'b0, y_red}) begin
      diff = {1'b0, sel} - {1'b0, y_red};
    end else begin
      diff = {1'b0, sel} + {1'b0, RAW_TOP} - {1'b0, y_red};
    end
  end
  assign last_new = diff[30:0];

  assign tbl_we = (cmd.red_seed && (cnt_r < CW'(TABLE_DEPTH))) || cmd.red_next;
  assign tbl_wa = cmd.red_next ? slot_r : cnt_r[AW-1:0];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    if (cmd.load_seed) begin
      x_nxt   = seed_eff;
      y_nxt   = seed_eff;
      cnt_nxt = CW'(TABLE_DEPTH + 7);
    end
    if (cmd.red_seed) begin
      x_nxt = x_red;
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        last_nxt = x_red;
      end
    end
    if (cmd.red_next) begin
      x_nxt    = x_red;
      y_nxt    = y_red;
      last_nxt = last_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= 31'd1;
      y_r    <= Y_INIT;
      last_r <= '0;
      cnt_r  <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      last_r <= last_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1_r   <= 47'(MUL1) * 47'(x_r);
      p2_r   <= 47'(MUL2) * 47'(y_r);
      slot_r <= slot;
    end
  end

  // shuffle table
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= x_red;
    if (cmd.mul) begin
      rd_r     <= tbl_mem[slot];
      rd_vld_r <= tbl_vld_r[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_wa] <= 1'b1;
    end
  end

  // output word register
  assign out_load = res_pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.red_next) begin
        res_pend_r <= 1'b1;
      end else if (out_load) begin
        res_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw_r  <= last_r;
      out_frac_r <= to_frac(last_r);
    end
  end

  assign sts.busy          = res_pend_r && !out_load;
  assign sts.cnt_zero      = (cnt_r == '0);
  assign out_valid         = out_valid_r;
  assign out_raw_value     = out_raw_r;
  assign out_unit_fraction = out_frac_r;

endmodule
`default_nettype wire

// File: rtl/core/combined_lcg_shuffle_rng_core.sv
// top level of the combined lcg generator with shuffle table
//
//   port group  dir  handshake           word
//   in_*        in   in_valid/in_ready   in_func, in_seed_value
//   out_*       out  out_valid/out_ready out_raw_value, out_unit_fraction
//
// next word: multiply, then fold and table update, both on the shared multiplier and fold
//   pair; the word passes a pending register, then the output register
// seed word: load, TABLE_DEPTH+8 multiply/fold steps (last TABLE_DEPTH fill table), next step
// reset: generators at 1 and 123456789, previous output 0, table reads as zero
// stalls: one output register plus one pending word; input stalls once both hold
`default_nettype none
module combined_lcg_shuffle_rng_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_func,
  input  wire  [30:0] in_seed_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [30:0] out_raw_value,
  output logic [31:0] out_unit_fraction
);
  import clsr_pkg::*;

  clsr_cmd_t cmd;
  clsr_sts_t sts;

  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_seed_value     (in_seed_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_value     (out_raw_value),
    .out_unit_fraction (out_unit_fraction)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_seed, cmd.mul, cmd.red_seed, cmd.red_next}))
    else $error("more than one datapath command");

  a_next_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_func) |=> cmd.red_next)
    else $error("next word not folded in the following cycle");

  a_fold_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red_next |-> !sts.busy)
    else $error("fold with a word still pending");

  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.red_seed && sts.cnt_zero) |=> cmd.mul)
    else $error("seed warm-up not followed by a deviate step");

endmodule
`default_nettype wire
